// ===== rtl/core/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types and constants shared by the response head parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_STATUS = 3'd1,
        PH_LINE   = 3'd2,
        PH_NAME   = 3'd3,
        PH_VALUE  = 3'd4,
        PH_BODY   = 3'd5
    } t_phase;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_HEAD_LEN = 4'd1;
    localparam logic [3:0] ERR_LINE_END = 4'd2;
    localparam logic [3:0] ERR_STATUS   = 4'd3;
    localparam logic [3:0] ERR_HDR_CNT  = 4'd4;
    localparam logic [3:0] ERR_HDR_LINE = 4'd5;
    localparam logic [3:0] ERR_VAL_CHAR = 4'd6;
    localparam logic [3:0] ERR_TE       = 4'd7;
    localparam logic [3:0] ERR_BAD_LEN  = 4'd8;
    localparam logic [3:0] ERR_NO_LEN   = 4'd9;
    localparam logic [3:0] ERR_TOO_BIG  = 4'd10;

    localparam logic [2:0] ADDR_MAX_BODY = 3'd0;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [9:0]  status_code;
        logic [23:0] content_length;
        logic        keep_alive;
        logic [3:0]  error_code;
        logic        last;
    } t_result;

    // lower case fold
    function automatic logic [7:0] f_lower(input logic [7:0] c);
        f_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        f_is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic f_is_ows(input logic [7:0] c);
        f_is_ows = (c == 8'h20 || c == 8'h09);
    endfunction

    // token character check
    function automatic logic f_is_tchar(input logic [7:0] c);
        logic r;
        r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || f_is_digit(c);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: ;
        endcase
        f_is_tchar = r;
    endfunction

    // watched names, lower case, indexed by position
    function automatic logic [7:0] f_te_char(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "n";
            5'd4: r = "s"; 5'd5: r = "f"; 5'd6: r = "e"; 5'd7: r = "r";
            5'd8: r = "-"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "c";
            5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
            5'd16: r = "g";
            default: r = 8'h00;
        endcase
        f_te_char = r;
    endfunction

    function automatic logic [7:0] f_cl_char(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t";
            5'd4: r = "e"; 5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-";
            5'd8: r = "l"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "g";
            5'd12: r = "t"; 5'd13: r = "h";
            default: r = 8'h00;
        endcase
        f_cl_char = r;
    endfunction

    function automatic logic [7:0] f_cn_char(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "n";
            5'd4: r = "e"; 5'd5: r = "c"; 5'd6: r = "t"; 5'd7: r = "i";
            5'd8: r = "o"; 5'd9: r = "n";
            default: r = 8'h00;
        endcase
        f_cn_char = r;
    endfunction

    function automatic logic [7:0] f_status_char(input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd0: r = "H"; 4'd1: r = "T"; 4'd2: r = "T"; 4'd3: r = "P";
            4'd4: r = "/"; 4'd5: r = "1"; 4'd6: r = "."; 4'd7: r = "1";
            default: r = 8'h00;
        endcase
        f_status_char = r;
    endfunction

    function automatic logic [7:0] f_close_char(input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd1: r = "l"; 4'd2: r = "o"; 4'd3: r = "s"; 4'd4: r = "e";
            default: r = 8'h00;
        endcase
        f_close_char = r;
    endfunction

endpackage

// ===== rtl/core/hrhp_cfg.sv =====
// ----------------------------------------------------------------------------
// hrhp_cfg
// Configuration register bank with its APB-style access port.
// ----------------------------------------------------------------------------
module hrhp_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [23:0] o_max_body_len,
    output logic [23:0] o_max_div10
);
    logic [23:0] r_max_body_len;
    logic [23:0] r_max_div10;
    logic [23:0] n_max_body_len;
    logic [47:0] w_prod;

    assign pready = 1'b1;

    // register write
    always_comb begin
        n_max_body_len = r_max_body_len;
        if (psel && penable && pwrite && paddr == hrhp_pkg::ADDR_MAX_BODY)
            n_max_body_len = pwdata[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_len <= 24'd16383;
        end else begin
            r_max_body_len <= n_max_body_len;
        end
    end

    // registered quotient by ten; config is quiet long before use
    assign w_prod = {24'd0, r_max_body_len} * 48'd13421773;
    always_ff @(posedge i_clk) begin
        r_max_div10 <= w_prod[47:24] >> 3;
    end

    // readback
    always_comb begin
        prdata = 32'd0;
        if (paddr == hrhp_pkg::ADDR_MAX_BODY)
            prdata = {8'd0, r_max_body_len};
    end

    assign o_max_body_len = r_max_body_len;
    assign o_max_div10    = r_max_div10;
endmodule

// ===== rtl/core/hrhp_core.sv =====
// ----------------------------------------------------------------------------
// hrhp_core
// Per-byte parser step: state registers and the result they produce.
// ----------------------------------------------------------------------------
module hrhp_core #(
    parameter int HEAD_MAX_BYTES   = 65536,
    parameter int MAX_HEADER_LINES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_c,
    input  logic               i_sor,
    input  logic [23:0]        i_max_body_len,
    input  logic [23:0]        i_max_div10,
    output logic               o_res_valid,
    output hrhp_pkg::t_result  o_res
);
    localparam int HCW = $clog2(HEAD_MAX_BYTES + 2);
    localparam int LCW = $clog2(MAX_HEADER_LINES + 2);

    hrhp_pkg::t_phase r_phase, n_phase, w_ph;
    logic [HCW-1:0] r_hcnt, n_hcnt, w_hcnt;
    logic [9:0]  r_st, n_st, w_st;
    logic [3:0]  r_spos, n_spos, w_spos;
    logic [LCW-1:0] r_lines, n_lines, w_lines;
    logic [2:0]  r_nm, n_nm, w_nm, w_nm2;
    logic [4:0]  r_npos, n_npos, w_npos;
    // one bit above the field so a last digit past the limit is still seen
    logic [24:0] r_len, n_len, w_len;
    logic        r_have, n_have, w_have;
    logic        r_incl, n_incl, w_incl;
    logic        r_dig, n_dig, w_dig;
    logic        r_trail, n_trail, w_trail;
    logic [3:0]  r_cts, n_cts, w_cts;
    logic        r_close, n_close, w_close;
    logic        r_cr, n_cr, w_cr;
    logic [23:0] r_body, n_body, w_body;
    logic [7:0]  w_lc;
    logic [13:0] w_st10;
    logic [28:0] w_len10;
    logic        w_fail;
    logic [3:0]  w_err;
    logic        w_put;
    hrhp_pkg::t_result w_res;

    assign w_lc    = hrhp_pkg::f_lower(i_c);
    assign w_st10  = {4'd0, r_st} * 14'd10 + {10'd0, i_c[3:0]};
    assign w_len10 = {4'd0, r_len} * 29'd10 + {25'd0, i_c[3:0]};

    // name match update for the current byte
    always_comb begin
        w_nm2 = (r_phase == hrhp_pkg::PH_LINE) ? 3'b111 : r_nm;
        w_npos = (r_phase == hrhp_pkg::PH_LINE) ? 5'd0 : r_npos;
        if (w_npos >= 5'd17 || w_lc != hrhp_pkg::f_te_char(w_npos)) w_nm2[0] = 1'b0;
        if (w_npos >= 5'd14 || w_lc != hrhp_pkg::f_cl_char(w_npos)) w_nm2[1] = 1'b0;
        if (w_npos >= 5'd10 || w_lc != hrhp_pkg::f_cn_char(w_npos)) w_nm2[2] = 1'b0;
    end

    // next state and result
    always_comb begin
        w_ph = r_phase; w_hcnt = r_hcnt; w_st = r_st; w_spos = r_spos;
        w_lines = r_lines; w_nm = r_nm; w_len = r_len;
        w_have = r_have; w_incl = r_incl; w_dig = r_dig; w_trail = r_trail;
        w_cts = r_cts; w_close = r_close; w_cr = r_cr; w_body = r_body;
        w_fail = 1'b0; w_err = hrhp_pkg::ERR_OK; w_put = 1'b0;
        w_res = '0;
        n_npos = r_npos;
        if (i_sor) begin
            w_ph = hrhp_pkg::PH_STATUS; w_hcnt = '0; w_st = '0; w_spos = '0;
            w_lines = '0; w_nm = '0; n_npos = '0; w_len = '0;
            w_have = 1'b0; w_incl = 1'b0; w_dig = 1'b0; w_trail = 1'b0;
            w_cts = '0; w_close = 1'b0; w_cr = 1'b0; w_body = '0;
        end
        n_phase = w_ph; n_hcnt = w_hcnt; n_st = w_st; n_spos = w_spos;
        n_lines = w_lines; n_nm = w_nm; n_len = w_len;
        n_have = w_have; n_incl = w_incl; n_dig = w_dig; n_trail = w_trail;
        n_cts = w_cts; n_close = w_close; n_cr = w_cr; n_body = w_body;

        if (w_ph == hrhp_pkg::PH_BODY) begin
            n_body = w_body - 24'd1;
            w_put = 1'b1;
            w_res.kind = 1'b1;
            w_res.body_byte = i_c;
            w_res.last = (w_body <= 24'd1);
            if (w_res.last) begin
                n_phase = hrhp_pkg::PH_STATUS; n_body = '0; n_hcnt = '0; n_st = '0;
                n_spos = '0; n_lines = '0; n_nm = '0; n_npos = '0; n_len = '0;
                n_have = 1'b0; n_incl = 1'b0; n_dig = 1'b0; n_trail = 1'b0;
                n_cts = '0; n_close = 1'b0; n_cr = 1'b0;
            end
        end else if (w_ph != hrhp_pkg::PH_IDLE) begin
            n_hcnt = w_hcnt + 1'b1;
            if (n_hcnt > HCW'(HEAD_MAX_BYTES)) begin
                w_fail = 1'b1; w_err = hrhp_pkg::ERR_HEAD_LEN;
            end else if (w_cr) begin
                n_cr = 1'b0;
                if (i_c != 8'h0A) begin
                    w_fail = 1'b1; w_err = hrhp_pkg::ERR_LINE_END;
                end else begin
                    // end of line
                    case (w_ph)
                        hrhp_pkg::PH_STATUS: begin
                            if (w_spos < 4'd10 || w_st < 10'd100 || w_st > 10'd599) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_STATUS;
                            end else n_phase = hrhp_pkg::PH_LINE;
                        end
                        hrhp_pkg::PH_LINE: begin
                            if (!w_have) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_NO_LEN;
                            end else if (w_len > {1'b0, i_max_body_len}) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_TOO_BIG;
                            end else begin
                                w_put = 1'b1;
                                w_res.status_code = w_st;
                                w_res.content_length = w_len[23:0];
                                w_res.keep_alive = !w_close;
                                w_res.last = (w_len == 25'd0);
                                if (w_len == 25'd0) begin
                                    n_phase = hrhp_pkg::PH_STATUS; n_hcnt = '0;
                                    n_st = '0; n_spos = '0; n_lines = '0; n_nm = '0;
                                    n_npos = '0; n_len = '0; n_have = 1'b0;
                                    n_incl = 1'b0; n_dig = 1'b0; n_trail = 1'b0;
                                    n_cts = '0; n_close = 1'b0; n_body = '0;
                                end else begin
                                    n_body = w_len[23:0];
                                    n_phase = hrhp_pkg::PH_BODY;
                                end
                            end
                        end
                        hrhp_pkg::PH_NAME: begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_HDR_LINE;
                        end
                        default: begin
                            if (w_incl && !w_dig) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_BAD_LEN;
                            end else begin
                                if (w_cts == 4'd6 || w_cts == 4'd7) n_close = 1'b1;
                                n_incl = 1'b0; n_dig = 1'b0; n_trail = 1'b0;
                                n_cts = '0;
                                n_phase = hrhp_pkg::PH_LINE;
                            end
                        end
                    endcase
                end
            end else if (i_c == 8'h00 || i_c == 8'h0A) begin
                w_fail = 1'b1; w_err = hrhp_pkg::ERR_LINE_END;
            end else if (i_c == 8'h0D) begin
                n_cr = 1'b1;
            end else begin
                case (w_ph)
                    hrhp_pkg::PH_STATUS: begin
                        if (w_spos < 4'd8) begin
                            if (i_c != hrhp_pkg::f_status_char(w_spos)) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_STATUS;
                            end else n_spos = w_spos + 4'd1;
                        end else if (w_spos == 4'd8 || w_spos == 4'd9) begin
                            if (hrhp_pkg::f_is_digit(i_c)) begin
                                n_st = {6'd0, i_c[3:0]};
                                n_spos = 4'd10;
                            end else if (w_spos == 4'd8 && i_c == 8'h2B) begin
                                n_spos = 4'd9;
                            end else if (!(w_spos == 4'd8 && (i_c == 8'h20 || i_c == 8'h09
                                         || i_c == 8'h0B || i_c == 8'h0C))) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_STATUS;
                            end
                        end else if (w_spos == 4'd10) begin
                            if (hrhp_pkg::f_is_digit(i_c))
                                n_st = (w_st10 > 14'd1000) ? 10'd1000 : w_st10[9:0];
                            else
                                n_spos = 4'd11;
                        end
                    end
                    hrhp_pkg::PH_LINE: begin
                        n_lines = w_lines + 1'b1;
                        if (n_lines > LCW'(MAX_HEADER_LINES)) begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_HDR_CNT;
                        end else if (!hrhp_pkg::f_is_tchar(i_c)) begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_HDR_LINE;
                        end else begin
                            n_phase = hrhp_pkg::PH_NAME;
                            n_nm = w_nm2;
                            n_npos = 5'd1;
                        end
                    end
                    hrhp_pkg::PH_NAME: begin
                        if (i_c == 8'h3A) begin
                            if (w_nm[0] && r_npos == 5'd17) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_TE;
                            end else if (w_nm[1] && r_npos == 5'd14 && w_have) begin
                                w_fail = 1'b1; w_err = hrhp_pkg::ERR_BAD_LEN;
                            end else begin
                                if (w_nm[1] && r_npos == 5'd14) begin
                                    n_have = 1'b1; n_incl = 1'b1;
                                end
                                if (w_nm[2] && r_npos == 5'd10) n_cts = 4'd1;
                                n_phase = hrhp_pkg::PH_VALUE;
                            end
                        end else if (!hrhp_pkg::f_is_tchar(i_c)) begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_HDR_LINE;
                        end else begin
                            n_nm = w_nm2;
                            if (r_npos < 5'd31) n_npos = r_npos + 5'd1;
                        end
                    end
                    default: begin
                        if ((i_c < 8'h20 && i_c != 8'h09) || i_c == 8'h7F) begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_VAL_CHAR;
                        end else if (w_incl && !hrhp_pkg::f_is_ows(i_c)
                                     && (!hrhp_pkg::f_is_digit(i_c) || w_trail
                                         || (w_dig && w_len == 25'd0)
                                         || w_len > {1'b0, i_max_div10})) begin
                            w_fail = 1'b1; w_err = hrhp_pkg::ERR_BAD_LEN;
                        end else begin
                            if (w_incl) begin
                                if (hrhp_pkg::f_is_ows(i_c)) begin
                                    if (w_dig) n_trail = 1'b1;
                                end else begin
                                    n_len = w_len10[24:0];
                                    n_dig = 1'b1;
                                end
                            end
                            // close token tracking
                            if (w_cts != 4'd0) begin
                                if (i_c == 8'h2C) begin
                                    if (w_cts == 4'd6 || w_cts == 4'd7) n_close = 1'b1;
                                    n_cts = 4'd1;
                                end else if (w_cts == 4'd1) begin
                                    if (!hrhp_pkg::f_is_ows(i_c))
                                        n_cts = (w_lc == 8'h63) ? 4'd2 : 4'd8;
                                end else if (w_cts >= 4'd2 && w_cts <= 4'd5) begin
                                    n_cts = (w_lc == hrhp_pkg::f_close_char(w_cts - 4'd1))
                                            ? w_cts + 4'd1 : 4'd8;
                                end else if (w_cts == 4'd6 || w_cts == 4'd7) begin
                                    n_cts = hrhp_pkg::f_is_ows(i_c) ? 4'd7 : 4'd8;
                                end
                            end
                        end
                    end
                endcase
            end
            if (w_fail) begin
                n_phase = hrhp_pkg::PH_IDLE;
                w_put = 1'b1;
                w_res = '0;
                w_res.error_code = w_err;
                w_res.last = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_IDLE;
            r_hcnt <= '0; r_st <= '0; r_spos <= '0; r_lines <= '0; r_nm <= '0;
            r_npos <= '0; r_len <= '0; r_have <= 1'b0; r_incl <= 1'b0;
            r_dig <= 1'b0; r_trail <= 1'b0; r_cts <= '0; r_close <= 1'b0;
            r_cr <= 1'b0; r_body <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_hcnt <= n_hcnt; r_st <= n_st; r_spos <= n_spos; r_lines <= n_lines;
            r_nm <= n_nm; r_npos <= n_npos; r_len <= n_len; r_have <= n_have;
            r_incl <= n_incl; r_dig <= n_dig; r_trail <= n_trail; r_cts <= n_cts;
            r_close <= n_close; r_cr <= n_cr; r_body <= n_body;
        end
    end

    assign o_res_valid = i_en && w_put;
    assign o_res = w_res;
endmodule

// ===== rtl/core/http_response_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_response_head_parser
// HTTP/1.1 response head checker with Content-Length body pass-through.
// ----------------------------------------------------------------------------
// path: an input item is registered in the input stage; any result item it
// yields is registered in the output register, or the skid stage on a stall
// throughput: one byte per cycle; the input stalls only while a result item
// waits in the skid stage
// reset: synchronous, active low; parser idles until a start byte,
// max_body_len returns to 16383
module http_response_head_parser #(
    parameter int HEAD_MAX_BYTES   = 65536,
    parameter int MAX_HEADER_LINES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_response,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_body_byte,
    output logic [9:0]  o_status_code,
    output logic [23:0] o_content_length,
    output logic        o_keep_alive,
    output logic [3:0]  o_error_code,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic        r_in_v;
    logic [7:0]  r_in_c;
    logic        r_in_sor;
    logic        w_adv;
    logic        w_rv;
    logic [23:0] w_max, w_div;
    hrhp_pkg::t_result w_res, r_out, r_skid;
    logic        r_out_v, r_skid_v;

    hrhp_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_max_body_len(w_max), .o_max_div10(w_div)
    );

    // input stage moves when the skid stage is empty
    assign o_stall = r_skid_v;
    assign w_adv   = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_adv) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_c   <= i_data_byte;
            r_in_sor <= i_start_of_response;
        end
    end

    hrhp_core #(
        .HEAD_MAX_BYTES(HEAD_MAX_BYTES), .MAX_HEADER_LINES(MAX_HEADER_LINES)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(r_in_v && w_adv),
        .i_c(r_in_c), .i_sor(r_in_sor), .i_max_body_len(w_max),
        .i_max_div10(w_div), .o_res_valid(w_rv), .o_res(w_res)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || !i_stall) begin
                r_out_v  <= r_skid_v || w_rv;
                r_skid_v <= 1'b0;
            end else if (w_rv) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_rv) begin
            r_skid <= w_res;
        end
    end

    assign o_valid          = r_out_v;
    assign o_result_kind    = r_out.kind;
    assign o_body_byte      = r_out.body_byte;
    assign o_status_code    = r_out.status_code;
    assign o_content_length = r_out.content_length;
    assign o_keep_alive     = r_out.keep_alive;
    assign o_error_code     = r_out.error_code;
    assign o_last           = r_out.last;
endmodule
